/* rtl/core/spos_pkg.sv */
package spos_pkg;

   // field and register widths
   localparam int VAL_W  = 32;
   localparam int SUM_W  = 44;
   localparam int NUM_W  = 32;
   localparam int CNT_W  = 13;
   localparam int SIDX_W = 12;
   localparam int OBJ_W  = 64;
   localparam int CSR_W  = 44;
   localparam int CSR_IDX_W = 2;

   // internal arithmetic widths
   localparam int DIFF1_W = SUM_W + CNT_W;          // prefix * right count
   localparam int SR_W    = SUM_W + 1;              // total - prefix
   localparam int DD_W    = SR_W + CNT_W + 2;       // scaled mean difference
   localparam int ABS_W   = DD_W - 1;
   localparam int SQ_W    = 2 * ABS_W;              // squared difference
   localparam int P_W     = 4 * CNT_W;              // k * rk * o * m
   localparam int NP_W    = NUM_W + P_W;            // |numerator| * p
   localparam int Q_W     = 64;
   localparam int NN_LO_W = 16;                     // bits of the product below 2^64 after << 48

   // step counts of the serial units
   localparam int SQ_STEPS  = ABS_W;
   localparam int NP_STEPS  = NUM_W;
   localparam int DIV_STEPS = Q_W;
   localparam int STEP_W    = 7;

   localparam logic [OBJ_W-1:0] OBJ_MAX = {1'b0, {(OBJ_W-1){1'b1}}};
   localparam logic [OBJ_W-1:0] OBJ_MIN = {1'b1, {(OBJ_W-1){1'b0}}};

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUMER = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP       = 4'd0,
      OP_ACCEPT    = 4'd1,
      OP_DIFF1     = 4'd2,
      OP_DIFF2     = 4'd3,
      OP_PROD1     = 4'd4,
      OP_PROD2     = 4'd5,
      OP_PROD3     = 4'd6,
      OP_ABS       = 4'd7,
      OP_SQ_LD     = 4'd8,
      OP_MUL_STEP  = 4'd9,
      OP_NP_LD     = 4'd10,
      OP_RO_LD     = 4'd11,
      OP_DIV_STEP  = 4'd12,
      OP_Q_LD      = 4'd13,
      OP_RESULT    = 4'd14
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic last_item;
      logic absd_zero;
      logic quot_ovf;
   } dp_status_type;

endpackage

/* rtl/core/spos_datapath.sv */
module spos_datapath
   import spos_pkg::*;
#(
   parameter int MAX_COUNT = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic signed [VAL_W-1:0]  req_value,
   input  logic [CNT_W-1:0]         cfg_count,
   input  logic signed [SUM_W-1:0]  cfg_total,
   input  logic signed [NUM_W-1:0]  cfg_numer,
   output logic [SIDX_W-1:0]        rsp_split_index,
   output logic signed [OBJ_W-1:0]  rsp_objective,
   output logic                     rsp_saturated,
   output logic                     rsp_last
);

   localparam int IW = (MAX_COUNT > 2) ? $clog2(MAX_COUNT) : 1;

   logic signed [SUM_W-1:0]   prefix_ff, prefix_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [CNT_W-1:0]          m_ff, m_in, k_ff, k_in, rk_ff, rk_in, o_ff, o_in;
   logic                      last_ff, last_in;
   logic [SIDX_W-1:0]         split_ff, split_in;
   logic signed [DIFF1_W-1:0] t1_ff, t1_in;
   logic signed [DD_W-1:0]    dd_ff, dd_in;
   logic [P_W-1:0]            p_ff, p_in;
   logic [ABS_W-1:0]          absd_ff, absd_in;
   logic                      zero_ff, zero_in;
   logic [SQ_W-1:0]           acc_ff, acc_in, ma_ff, ma_in;
   logic [ABS_W-1:0]          mb_ff, mb_in;
   logic [SQ_W-1:0]           dn_ff, dn_in;
   logic [NP_W-1:0]           nprod_ff, nprod_in;
   logic [SQ_W-1:0]           rem_ff, rem_in, dv_ff, dv_in;
   logic [Q_W-1:0]            dl_ff, dl_in, q_ff, q_in, ro_ff, ro_in;
   logic                      ovf_ff, ovf_in;
   logic [SIDX_W-1:0]         out_idx_ff, out_idx_in;
   logic [OBJ_W-1:0]          out_obj_ff, out_obj_in;
   logic                      out_sat_ff, out_sat_in, out_last_ff, out_last_in;

   logic [CNT_W-1:0]          m_eff, k_new;
   logic                      last_item;
   logic signed [SR_W-1:0]    sr;
   logic [NUM_W-1:0]          absn;
   logic                      quot_ovf;
   logic [SQ_W:0]             div_t;
   logic                      div_ge;
   logic [SQ_W:0]             div_sub;
   logic [OBJ_W-1:0]          diff, sum, lim, res;
   logic                      sat;

   // clamp of the sample count
   always_comb begin
      if (cfg_count < CNT_W'(2)) begin
         m_eff = CNT_W'(2);
      end else if (32'(cfg_count) > MAX_COUNT) begin
         m_eff = CNT_W'(MAX_COUNT);
      end else begin
         m_eff = cfg_count;
      end
   end

   assign last_item = (32'(idx_ff) + 32'd1) >= 32'(m_eff);
   assign k_new     = CNT_W'(32'(idx_ff) + 32'd1);
   assign sr        = SR_W'(cfg_total) - SR_W'(prefix_ff);
   assign absn      = cfg_numer[NUM_W-1] ? (~cfg_numer + NUM_W'(1)) : cfg_numer;
   assign quot_ovf  = SQ_W'(nprod_ff[NP_W-1:NN_LO_W]) >= dn_ff;

   // one radix-2 divide step
   assign div_t   = {rem_ff, dl_ff[Q_W-1]};
   assign div_ge  = div_t >= {1'b0, dv_ff};
   assign div_sub = div_t - {1'b0, dv_ff};

   // final objective with saturation
   assign diff = q_ff - ro_ff;
   assign sum  = q_ff + ro_ff;
   assign lim  = OBJ_MIN - ro_ff;
   always_comb begin
      sat = 1'b0;
      res = diff;
      if (zero_ff) begin
         sat = 1'b1;
         res = cfg_numer[NUM_W-1] ? OBJ_MIN : OBJ_MAX;
      end else if (!cfg_numer[NUM_W-1]) begin
         if (ovf_ff || (q_ff >= ro_ff && diff[OBJ_W-1])) begin
            sat = 1'b1;
            res = OBJ_MAX;
         end
      end else begin
         if (ovf_ff || q_ff > lim) begin
            sat = 1'b1;
            res = OBJ_MIN;
         end else begin
            res = OBJ_W'(0) - sum;
         end
      end
   end

   always_comb begin
      prefix_in = prefix_ff;
      idx_in    = idx_ff;
      m_in      = m_ff;
      k_in      = k_ff;
      rk_in     = rk_ff;
      o_in      = o_ff;
      last_in   = last_ff;
      split_in  = split_ff;
      t1_in     = t1_ff;
      dd_in     = dd_ff;
      p_in      = p_ff;
      absd_in   = absd_ff;
      zero_in   = zero_ff;
      acc_in    = acc_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      dn_in     = dn_ff;
      nprod_in  = nprod_ff;
      rem_in    = rem_ff;
      dv_in     = dv_ff;
      dl_in     = dl_ff;
      q_in      = q_ff;
      ro_in     = ro_ff;
      ovf_in    = ovf_ff;
      out_idx_in  = out_idx_ff;
      out_obj_in  = out_obj_ff;
      out_sat_in  = out_sat_ff;
      out_last_in = out_last_ff;
      case (cmd.op)
         OP_ACCEPT: begin
            if (last_item) begin
               prefix_in = '0;
               idx_in    = '0;
            end else begin
               prefix_in = prefix_ff + SUM_W'(req_value);
               idx_in    = idx_ff + IW'(1);
               m_in      = m_eff;
               k_in      = k_new;
               rk_in     = m_eff - k_new;
               o_in      = ({k_new, 1'b0} < {1'b0, m_eff}) ? (m_eff - k_new) : k_new;
               last_in   = (32'(k_new) + 32'd1) == 32'(m_eff);
               split_in  = SIDX_W'(idx_ff);
            end
         end
         OP_DIFF1: t1_in = DIFF1_W'(prefix_ff) * $signed({1'b0, rk_ff});
         OP_DIFF2: dd_in = DD_W'(t1_ff) - DD_W'(sr) * $signed({1'b0, k_ff});
         OP_PROD1: p_in = P_W'(P_W'(k_ff) * P_W'(rk_ff));
         OP_PROD2: p_in = P_W'((3*CNT_W)'(p_ff[2*CNT_W-1:0]) * (3*CNT_W)'(o_ff));
         OP_PROD3: p_in = P_W'(p_ff[3*CNT_W-1:0]) * P_W'(m_ff);
         OP_ABS: begin
            absd_in = dd_ff[DD_W-1] ? ABS_W'(-dd_ff) : ABS_W'(dd_ff);
            zero_in = (dd_ff == '0);
         end
         OP_SQ_LD: begin
            acc_in = '0;
            ma_in  = SQ_W'(absd_ff);
            mb_in  = absd_ff;
         end
         OP_MUL_STEP: begin
            acc_in = mb_ff[0] ? (acc_ff + ma_ff) : acc_ff;
            ma_in  = {ma_ff[SQ_W-2:0], 1'b0};
            mb_in  = {1'b0, mb_ff[ABS_W-1:1]};
         end
         OP_NP_LD: begin
            dn_in  = acc_ff;
            acc_in = '0;
            ma_in  = SQ_W'(p_ff);
            mb_in  = ABS_W'(absn);
         end
         OP_RO_LD: begin
            nprod_in = acc_ff[NP_W-1:0];
            rem_in   = '0;
            dv_in    = SQ_W'(m_ff);
            dl_in    = Q_W'({o_ff, 32'd0});
            q_in     = '0;
         end
         OP_DIV_STEP: begin
            rem_in = div_ge ? div_sub[SQ_W-1:0] : div_t[SQ_W-1:0];
            dl_in  = {dl_ff[Q_W-2:0], 1'b0};
            q_in   = {q_ff[Q_W-2:0], div_ge};
         end
         OP_Q_LD: begin
            ro_in  = q_ff;
            ovf_in = quot_ovf;
            rem_in = SQ_W'(nprod_ff[NP_W-1:NN_LO_W]);
            dv_in  = dn_ff;
            dl_in  = {nprod_ff[NN_LO_W-1:0], (Q_W-NN_LO_W)'(0)};
            q_in   = '0;
         end
         OP_RESULT: begin
            out_idx_in  = split_ff;
            out_obj_in  = res;
            out_sat_in  = sat;
            out_last_in = last_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         idx_ff    <= '0;
      end else begin
         prefix_ff <= prefix_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      k_ff        <= k_in;
      rk_ff       <= rk_in;
      o_ff        <= o_in;
      last_ff     <= last_in;
      split_ff    <= split_in;
      t1_ff       <= t1_in;
      dd_ff       <= dd_in;
      p_ff        <= p_in;
      absd_ff     <= absd_in;
      zero_ff     <= zero_in;
      acc_ff      <= acc_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      dn_ff       <= dn_in;
      nprod_ff    <= nprod_in;
      rem_ff      <= rem_in;
      dv_ff       <= dv_in;
      dl_ff       <= dl_in;
      q_ff        <= q_in;
      ro_ff       <= ro_in;
      ovf_ff      <= ovf_in;
      out_idx_ff  <= out_idx_in;
      out_obj_ff  <= out_obj_in;
      out_sat_ff  <= out_sat_in;
      out_last_ff <= out_last_in;
   end

   assign status.last_item = last_item;
   assign status.absd_zero = zero_ff;
   assign status.quot_ovf  = quot_ovf;

   assign rsp_split_index = out_idx_ff;
   assign rsp_objective   = out_obj_ff;
   assign rsp_saturated   = out_sat_ff;
   assign rsp_last        = out_last_ff;

endmodule

/* rtl/core/spos_ctrl.sv */
module spos_ctrl
   import spos_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_DIFF1 = 16'h0002,
      S_DIFF2 = 16'h0004,
      S_PROD1 = 16'h0008,
      S_PROD2 = 16'h0010,
      S_PROD3 = 16'h0020,
      S_ABS   = 16'h0040,
      S_SQ_LD = 16'h0080,
      S_SQ    = 16'h0100,
      S_NP_LD = 16'h0200,
      S_NP    = 16'h0400,
      S_RO_LD = 16'h0800,
      S_RO    = 16'h1000,
      S_Q_LD  = 16'h2000,
      S_Q     = 16'h4000,
      S_DONE  = 16'h8000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.op       = OP_NOP;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               if (!status.last_item) begin
                  state_in = S_DIFF1;
               end
            end
         end
         S_DIFF1: begin
            cmd.op   = OP_DIFF1;
            state_in = S_DIFF2;
         end
         S_DIFF2: begin
            cmd.op   = OP_DIFF2;
            state_in = S_PROD1;
         end
         S_PROD1: begin
            cmd.op   = OP_PROD1;
            state_in = S_PROD2;
         end
         S_PROD2: begin
            cmd.op   = OP_PROD2;
            state_in = S_PROD3;
         end
         S_PROD3: begin
            cmd.op   = OP_PROD3;
            state_in = S_ABS;
         end
         S_ABS: begin
            cmd.op   = OP_ABS;
            state_in = S_SQ_LD;
         end
         S_SQ_LD: begin
            cmd.op   = OP_SQ_LD;
            cnt_in   = STEP_W'(SQ_STEPS - 1);
            state_in = status.absd_zero ? S_DONE : S_SQ;
         end
         S_SQ: begin
            cmd.op = OP_MUL_STEP;
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_NP_LD;
            end
         end
         S_NP_LD: begin
            cmd.op   = OP_NP_LD;
            cnt_in   = STEP_W'(NP_STEPS - 1);
            state_in = S_NP;
         end
         S_NP: begin
            cmd.op = OP_MUL_STEP;
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_RO_LD;
            end
         end
         S_RO_LD: begin
            cmd.op   = OP_RO_LD;
            cnt_in   = STEP_W'(DIV_STEPS - 1);
            state_in = S_RO;
         end
         S_RO: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_Q_LD;
            end
         end
         S_Q_LD: begin
            cmd.op   = OP_Q_LD;
            cnt_in   = STEP_W'(DIV_STEPS - 1);
            state_in = status.quot_ovf ? S_DONE : S_Q;
         end
         S_Q: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.op       = OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/core/split_point_objective_scan.sv */
// sequencing: each accepted sample runs through the serial shift-add multiplier (59 + 32
//   steps) and the radix-2 divider (2 x 64 steps) before its response beat is loaded
// flow: req_stall is held until the response is loaded, which waits on rsp_stall; the
//   closing sample of a scan gives no response, a zero mean difference skips the rest
// reset: synchronous active high; clears prefix sum, item index, controller and response
//   valid; count returns to 2, total_sum and numerator to 0
module split_point_objective_scan
   import spos_pkg::*;
#(
   parameter int MAX_COUNT = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [VAL_W-1:0]  req_value,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SIDX_W-1:0]        rsp_split_index,
   output logic signed [OBJ_W-1:0]  rsp_objective,
   output logic                     rsp_saturated,
   output logic                     rsp_last,
   // register write port
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   // configuration registers
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] total_ff, total_in;
   logic signed [NUM_W-1:0] numer_ff, numer_in;

   dp_cmd_type    cmd;
   dp_status_type status;

   // register writes; an index past the list is dropped
   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      numer_in = numer_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COUNT: count_in = csr_wdata[CNT_W-1:0];
            CSR_TOTAL: total_in = csr_wdata[SUM_W-1:0];
            CSR_NUMER: numer_in = csr_wdata[NUM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(2);
         total_ff <= '0;
         numer_ff <= '0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         numer_ff <= numer_in;
      end
   end

   // sequencer: accept, then mean difference, products, square, divides, result
   spos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic, scan state and the response register
   spos_datapath #(
      .MAX_COUNT (MAX_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_value       (req_value),
      .cfg_count       (count_ff),
      .cfg_total       (total_ff),
      .cfg_numer       (numer_ff),
      .rsp_split_index (rsp_split_index),
      .rsp_objective   (rsp_objective),
      .rsp_saturated   (rsp_saturated),
      .rsp_last        (rsp_last)
   );

endmodule

/* tb/split_point_objective_scan_tb.sv */
`timescale 1ns / 100ps

module split_point_objective_scan_tb
   import spos_pkg::*;
();

   localparam int  MAX_M      = 4096;
   localparam int  DRAIN_WAIT = 300;      // longer than the block takes over one item
   localparam longint CYCLE_LIMIT = 4000000;

   // one expected response beat
   typedef struct {
      logic [SIDX_W-1:0] split_index;
      logic [OBJ_W-1:0]  objective;
      logic              saturated;
      logic              last;
   } split_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [SIDX_W-1:0]       rsp_split_index;
   logic signed [OBJ_W-1:0] rsp_objective;
   logic                    rsp_saturated;
   logic                    rsp_last;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;

   split_point_objective_scan #(.MAX_COUNT(MAX_M)) uut (.*);

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the block's registers and scan state
   logic [CNT_W-1:0]        count_reg;
   logic signed [SUM_W-1:0] total_reg;
   logic signed [NUM_W-1:0] numer_reg;
   logic [SUM_W-1:0]        run_prefix;
   int unsigned             scan_pos;

   split_result_type objective_q[$];

   int     mismatches = 0;
   int     beats_sent = 0;
   int     beats_checked = 0;
   int     sat_seen = 0;
   int     scans_done = 0;
   longint cycles = 0;

   // sender pacing: bursts and gaps, can be switched off for the pressure test
   int burst_left = 0;
   bit no_gaps = 1'b0;

   // receiver hold-off request, counted down by the stall process
   int hold_len = 0;

   // works out the response for one sample, returns 0 when the sample closes the scan
   function automatic bit scan_objective(input logic signed [VAL_W-1:0] v,
                                         output split_result_type r);
      longint unsigned m, k, rk, o, p, ro, q64, res, absd, absn;
      longint sl, sr, dd, num;
      logic [191:0] nn, dn, quo;
      bit sat;
      m = count_reg;
      if (m < 2) m = 2;
      if (m > MAX_M) m = MAX_M;
      run_prefix = run_prefix + {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
      if (longint'(scan_pos) + 1 >= m) begin
         run_prefix = '0;
         scan_pos = 0;
         scans_done++;
         return 1'b0;
      end
      sat = 1'b0;
      k = scan_pos + 1;
      rk = m - k;
      o = (2 * k < m) ? rk : k;
      sl = longint'($signed(run_prefix));
      sr = longint'(total_reg) - sl;
      dd = sl * longint'(rk) - sr * longint'(k);
      absd = (dd < 0) ? -dd : dd;
      num = longint'(numer_reg);
      absn = (num < 0) ? -num : num;
      ro = (o << 32) / m;
      if (absd == 0) begin
         // equal means: clamp by the sign of the numerator
         sat = 1'b1;
         res = (num < 0) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
         p = k * rk * o * m;
         nn = (192'(absn) * 192'(p)) << 48;
         dn = 192'(absd) * 192'(absd);
         quo = nn / dn;
         if (quo[191:64] != '0) begin
            sat = 1'b1;
            q64 = 0;
         end else begin
            q64 = quo[63:0];
         end
         if (num >= 0) begin
            if (sat) res = 64'h7FFF_FFFF_FFFF_FFFF;
            else if (q64 >= ro) begin
               res = q64 - ro;
               if (res > 64'h7FFF_FFFF_FFFF_FFFF) begin
                  sat = 1'b1;
                  res = 64'h7FFF_FFFF_FFFF_FFFF;
               end
            end else res = -(ro - q64);
         end else begin
            if (sat || q64 > 64'h8000_0000_0000_0000 - ro) begin
               sat = 1'b1;
               res = 64'h8000_0000_0000_0000;
            end else res = -(q64 + ro);
         end
      end
      r.split_index = scan_pos[SIDX_W-1:0];
      r.objective = res;
      r.saturated = sat;
      r.last = (k + 1 == m);
      scan_pos++;
      return 1'b1;
   endfunction

   // register write, only called while the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_COUNT: count_reg = data[CNT_W-1:0];
         CSR_TOTAL: total_reg = data[SUM_W-1:0];
         CSR_NUMER: numer_reg = data[NUM_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_scan(input int m, input longint tot, input int numer);
      write_reg(CSR_COUNT, CSR_W'(m));
      write_reg(CSR_TOTAL, CSR_W'(tot));
      write_reg(CSR_NUMER, CSR_W'(numer));
   endtask

   // wait for all expected beats, then for the last sample to finish inside the block
   task automatic wait_idle();
      while (objective_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // offers one sample beat, holds it until accepted, then paces the next one
   task automatic send_value(input logic signed [VAL_W-1:0] v);
      split_result_type r;
      @(negedge clock);
      req_valid = 1'b1;
      req_value = v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (scan_objective(v, r)) objective_q.push_back(r);
      if (!no_gaps) begin
         if (burst_left > 0) burst_left--;
         else begin
            burst_left = $urandom_range(0, 7);
            @(negedge clock);
            req_valid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(100, 400)
                                              : $urandom_range(0, 40)) @(negedge clock);
         end
      end
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // receiver stall: long hold-off on request, otherwise a pattern of changing density
   initial begin : rsp_stall_gen
      int mode_left;
      int density;
      mode_left = 0;
      density = 0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_stall = 1'b1;
            hold_len--;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(20, 600);
               case ($urandom_range(0, 2))
                  0: density = 0;
                  1: density = 30;
                  default: density = 85;
               endcase
            end
            mode_left--;
            rsp_stall = ($urandom_range(0, 99) < density);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (objective_q.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR: unexpected beat split %0d objective %h",
                        rsp_split_index, rsp_objective);
            mismatches++;
         end else begin
            split_result_type e;
            e = objective_q.pop_front();
            beats_checked++;
            if (rsp_saturated) sat_seen++;
            if (rsp_split_index !== e.split_index || rsp_objective !== e.objective ||
                rsp_saturated !== e.saturated || rsp_last !== e.last) begin
               if (mismatches < 10)
                  $display({"ERROR: split exp %0d got %0d, obj exp %h got %h, ",
                            "sat exp %b got %b, last exp %b got %b"},
                           e.split_index, rsp_split_index, e.objective, rsp_objective,
                           e.saturated, rsp_saturated, e.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // defaults after reset: M = 2, zero total and numerator
   task automatic test_reset_state();
      send_value(32'sh7FFF_FFFF);
      send_value(32'sh8000_0000);
      end_burst();
      wait_idle();
   endtask

   // field and register extremes
   task automatic test_extremes();
      set_scan(4, 64'sh7FF_FFFF_FFFF, 32'sh7FFF_FFFF);
      send_value(32'sh8000_0000);
      send_value(32'sh7FFF_FFFF);
      send_value(32'sh0000_0000);
      send_value(32'shFFFF_FFFF);
      end_burst();
      wait_idle();
      set_scan(5, -64'sh800_0000_0000, 32'sh8000_0000);
      send_value(32'sh7FFF_FFFF);
      send_value(32'sh8000_0000);
      send_value(32'sh0000_0001);
      send_value(32'sh1234_5678);
      send_value(32'shFFFF_0000);
      end_burst();
      wait_idle();
   endtask

   // equal means on both sides, both signs of numerator
   task automatic test_equal_means();
      set_scan(3, 3 * 64'sh1_0000, 32'sh0001_0000);
      repeat (3) send_value(32'sh0001_0000);
      end_burst();
      wait_idle();
      write_reg(CSR_NUMER, CSR_W'(-32'sh0002_0000));
      repeat (3) send_value(32'sh0001_0000);
      end_burst();
      wait_idle();
   endtask

   // tiny mean difference with large numerator drives the objective past Q32.32
   task automatic test_overflow();
      set_scan(3, 1, 32'sh7FFF_FFFF);
      send_value(0);
      send_value(1);
      send_value(0);
      end_burst();
      wait_idle();
      write_reg(CSR_NUMER, CSR_W'(32'sh8000_0001));
      send_value(0);
      send_value(1);
      send_value(0);
      end_burst();
      wait_idle();
   endtask

   // counts below two, above the maximum, and a count lowered during a scan
   task automatic test_count_cases();
      set_scan(0, 64'sh5_0000, 32'sh0000_8000);
      send_value(32'sh0001_0000);
      send_value(32'sh0004_0000);
      end_burst();
      wait_idle();
      write_reg(CSR_COUNT, CSR_W'(1));
      send_value(32'sh0002_0000);
      send_value(32'sh0003_0000);
      end_burst();
      wait_idle();
      write_reg(CSR_COUNT, CSR_W'(13'h1FFF));
      send_value(32'sh0000_1000);
      send_value(32'sh0000_2000);
      send_value(32'sh0000_3000);
      end_burst();
      wait_idle();
      // position is now past the new M - 1, so the next sample closes the scan
      write_reg(CSR_COUNT, CSR_W'(2));
      send_value(32'sh0000_4000);
      send_value(32'sh0000_5000);
      send_value(32'sh0000_6000);
      end_burst();
      wait_idle();
   endtask

   // receiver holds off a long time while samples keep coming
   task automatic test_backpressure();
      set_scan(16, 16 * 64'sh3_0000, 32'sh0010_0000);
      hold_len = 3000;
      no_gaps = 1'b1;
      for (int n = 0; n < 16; n++) send_value(32'sh0000_8000 * n - 32'sh0001_0000);
      end_burst();
      no_gaps = 1'b0;
      wait_idle();
   endtask

   // random scans, mostly sorted with a matching total, some noise
   task automatic test_random_scans(input int n_items);
      int sent;
      int m;
      int noise;
      longint tot;
      logic signed [VAL_W-1:0] vals[$];
      logic signed [VAL_W-1:0] v;
      sent = 0;
      while (sent < n_items) begin
         m = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(2, 14);
         noise = ($urandom_range(0, 4) == 0);
         vals.delete();
         tot = 0;
         v = $signed($urandom) >>> $urandom_range(0, 14);
         for (int n = 0; n < m; n++) begin
            if (noise) v = $urandom;
            else v = v + $urandom_range(0, 32'd1 << $urandom_range(0, 20));
            vals.push_back(v);
            tot += longint'(v);
         end
         if (noise && $urandom_range(0, 1)) tot = {$urandom, $urandom};
         case ($urandom_range(0, 3))
            0: set_scan(m, tot, $urandom);
            1: set_scan(m, tot, $signed($urandom) >>> $urandom_range(8, 28));
            default: set_scan(m, tot, $urandom_range(0, 32'h0100_0000));
         endcase
         foreach (vals[n]) send_value(vals[n]);
         end_burst();
         sent += m;
         wait_idle();
      end
   endtask

   initial begin
      count_reg = 2;
      total_reg = '0;
      numer_reg = '0;
      run_prefix = '0;
      scan_pos = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_extremes();
      test_equal_means();
      test_overflow();
      test_count_cases();
      test_backpressure();
      test_random_scans(520);

      wait_idle();
      $display("covered %0d sample beats, %0d response beats checked, %0d saturated",
               beats_sent, beats_checked, sat_seen);
      $display("%0d scans closed, %0d mismatches, %0d cycles", scans_done, mismatches, cycles);
      if (mismatches == 0 && objective_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
